>>> rtl/bmorph_pkg.sv
// ============================================================================
// bmorph_pkg: shared types and constants for the 3x3 binary morphology block
// Item layouts, register indexes and pixel codes used across the design.
// ============================================================================
package bmorph_pkg;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DILATE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
    localparam logic [DIM_W-1:0] DIM_MIN   = 11'd3;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             flush;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_pix_out;

    // Per-item control carried from the input stage to the result stage.
    typedef struct packed {
        logic emit;
        logic flush;
        logic interior;
        logic frame_end;
    } t_s1_ctl;

endpackage

>>> rtl/binary_morphology_3x3.sv
// An accepted item goes to the tap and stage-one registers, its result to the result register.
// Throughput: one item per clock unless the output stalls; one memory write (none for a flush)
// and two reads per item; the 3x3 decision sits between the tap and result registers.
// Results start once frame_width+1 pixels are pending; a flush item drains one pending pixel.
// Reset: synchronous, active low; clears counters, pipeline valids and registers
// (dilate_mode 0, frame_width and frame_height 1024). The line memory is not cleared.
// ============================================================================
// binary_morphology_3x3: streaming 3x3 binary erosion and dilation
// Two line taps from a circular pixel memory feed a 3x3 window; the centre
// pixel is switched between 0 and 255 when a neighbor matches the mode.
// ============================================================================
module binary_morphology_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmorph_pkg::APB_AW-1:0]       paddr,
    input  logic [bmorph_pkg::APB_DW-1:0]       pwdata,
    output logic [bmorph_pkg::APB_DW-1:0]       prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bmorph_pkg::t_pix_in                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bmorph_pkg::t_pix_out                o_out_data
);

    localparam int AW     = $clog2(2 * MAX_WIDTH + 1);
    localparam int DEPTH  = 1 << AW;
    localparam int DW     = bmorph_pkg::DIM_W;
    localparam int PW     = bmorph_pkg::PIX_W;
    localparam int CW     = DW + 2;
    localparam int PEND_W = DW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          r_dilate;
    logic [DW-1:0] r_fwidth;
    logic [DW-1:0] r_fheight;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          geom_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[bmorph_pkg::APB_AW-1:2];
    assign geom_wr = cfg_wr && (cfg_idx == bmorph_pkg::REG_WIDTH ||
                                cfg_idx == bmorph_pkg::REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dilate  <= 1'b0;
            r_fwidth  <= bmorph_pkg::DIM_RESET;
            r_fheight <= bmorph_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bmorph_pkg::REG_DILATE: r_dilate  <= pwdata[0];
                bmorph_pkg::REG_WIDTH:  r_fwidth  <= pwdata[DW-1:0];
                bmorph_pkg::REG_HEIGHT: r_fheight <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bmorph_pkg::REG_DILATE: prdata = bmorph_pkg::APB_DW'(r_dilate);
            bmorph_pkg::REG_WIDTH:  prdata = bmorph_pkg::APB_DW'(r_fwidth);
            bmorph_pkg::REG_HEIGHT: prdata = bmorph_pkg::APB_DW'(r_fheight);
            default:                prdata = '0;
        endcase
    end

    // Effective geometry: width clamped to 3..MAX_WIDTH, height to at least 3.
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    always_comb begin
        if (r_fwidth < bmorph_pkg::DIM_MIN) begin
            w_eff = bmorph_pkg::DIM_MIN;
        end else if (CW'(r_fwidth) > CW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = r_fwidth;
        end
        h_eff = (r_fheight < bmorph_pkg::DIM_MIN) ? bmorph_pkg::DIM_MIN : r_fheight;
    end

    // ------------------------------------------------------------------
    // Input stage: counters, memory write and tap reads
    // ------------------------------------------------------------------
    logic [AW-1:0]     r_wp;
    logic [PEND_W-1:0] r_pending;
    logic [DW-1:0]     r_col;
    logic [DW-1:0]     r_row;
    logic [PW-1:0]     r_mem [DEPTH];
    logic [PW-1:0]     r_tap_a;
    logic [PW-1:0]     r_tap_b;

    logic                in_acc;
    logic                is_flush;
    logic [PEND_W-1:0]   w_p1;
    logic                emit;
    logic                col_last;
    logic                row_last;
    logic [AW-1:0]       addr_a;
    logic [AW-1:0]       addr_b;
    bmorph_pkg::t_s1_ctl ctl;

    assign in_acc   = i_in_valid && o_in_ready;
    assign is_flush = i_in_data.flush;
    assign w_p1     = {1'b0, w_eff} + PEND_W'(1);
    assign col_last = ({1'b0, r_col} + PEND_W'(1)) >= {1'b0, w_eff};
    assign row_last = ({1'b0, r_row} + PEND_W'(1)) >= {1'b0, h_eff};

    always_comb begin
        // A pixel emits once the window has filled; a flush drains the oldest pending pixel.
        emit = is_flush ? (r_pending != '0) : (r_pending >= w_p1);
        ctl.emit      = emit;
        ctl.flush     = is_flush;
        ctl.interior  = !is_flush && (r_pending == w_p1) &&
                        (r_row != '0) &&
                        (({1'b0, r_row} + PEND_W'(2)) <= {1'b0, h_eff}) &&
                        (r_col != '0) &&
                        (({1'b0, r_col} + PEND_W'(2)) <= {1'b0, w_eff});
        ctl.frame_end = (r_row == h_eff - DW'(1)) && (r_col == w_eff - DW'(1));
    end

    // Tap A is one line back from the new pixel, or the oldest pending pixel on a flush.
    assign addr_a = is_flush ? (r_wp - AW'(r_pending)) : (r_wp - AW'(w_eff));
    assign addr_b = r_wp - AW'({w_eff, 1'b0});

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_flush) begin
            r_mem[r_wp] <= i_in_data.pixel_in;
        end
        if (in_acc) begin
            r_tap_a <= r_mem[addr_a];
            r_tap_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_pending <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else if (geom_wr) begin
            r_pending <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else if (in_acc) begin
            if (!is_flush) begin
                r_wp <= r_wp + AW'(1);
                if (!emit) begin
                    r_pending <= r_pending + PEND_W'(1);
                end
            end else if (emit) begin
                r_pending <= r_pending - PEND_W'(1);
            end
            if (emit) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + DW'(1);
                end else begin
                    r_col <= r_col + DW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Window stage and result register
    // ------------------------------------------------------------------
    logic                r_v1;
    bmorph_pkg::t_s1_ctl r_s1;
    logic [PW-1:0]       r_pix1;
    logic [PW-1:0]       r_win_b0, r_win_b1;
    logic [PW-1:0]       r_win_m0, r_win_m1;
    logic [PW-1:0]       r_win_t0, r_win_t1;
    logic                r_ov;
    bmorph_pkg::t_pix_out r_out;

    logic          adv1;
    logic [PW-1:0] look;
    logic [PW-1:0] target;
    logic          hit;
    logic [PW-1:0] result;

    assign adv1       = r_v1 && (!r_s1.emit || !r_ov || i_out_ready);
    assign o_in_ready = !r_v1 || adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_acc) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1   <= ctl;
            r_pix1 <= i_in_data.pixel_in;
        end
    end

    // The window holds the two previous columns; the newest column comes from stage one.
    always_ff @(posedge i_clk) begin
        if (adv1 && !r_s1.flush) begin
            r_win_b1 <= r_win_b0;
            r_win_b0 <= r_pix1;
            r_win_m1 <= r_win_m0;
            r_win_m0 <= r_tap_a;
            r_win_t1 <= r_win_t0;
            r_win_t0 <= r_tap_b;
        end
    end

    always_comb begin
        look   = r_dilate ? bmorph_pkg::PIX_WHITE : bmorph_pkg::PIX_BLACK;
        target = r_dilate ? bmorph_pkg::PIX_BLACK : bmorph_pkg::PIX_WHITE;
        hit    = (r_pix1 == look) || (r_win_b0 == look) || (r_win_b1 == look) ||
                 (r_tap_a == look) || (r_win_m1 == look) ||
                 (r_tap_b == look) || (r_win_t0 == look) || (r_win_t1 == look);
        if (r_s1.flush) begin
            result = r_tap_a;
        end else if (r_s1.interior && hit && (r_win_m0 == target)) begin
            result = look;
        end else begin
            result = r_win_m0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv1 && r_s1.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_s1.emit) begin
            r_out.pixel_out <= result;
            r_out.frame_end <= r_s1.frame_end;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= w_p1)
        else $error("pending pixel count exceeds one line plus one");

    a_position_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < w_eff) && (r_row < h_eff))
        else $error("output position outside the frame");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_flush && r_pending == '0 && !geom_wr) |=> !r_s1.emit)
        else $error("flush with nothing pending produced an item");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid ##1 o_out_valid) |-> $past(r_v1 && r_s1.emit))
        else $error("result item appeared without an emitting stage");
`endif

endmodule
